[src/clrw_pkg.sv]
`default_nettype none

package clrw_pkg;

  localparam int MAX_LINES = 64;
  localparam int MAX_WIDTH = 128;

  localparam int SLOT_W = $clog2(MAX_LINES);
  localparam int LEN_W  = $clog2(MAX_WIDTH + 1);
  localparam int CNT_W  = $clog2(MAX_LINES + 1);
  localparam int ADDR_W = $clog2(MAX_LINES * MAX_WIDTH);

  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_CR = 8'd13;

  localparam logic [7:0] WIDTH_RESET = 8'd80;

  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 2;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [CNT_W-1:0]  cnt_t;

endpackage

`default_nettype wire

[src/console_line_ring_writer_top.sv]
// The input register holds an accepted word; its result word is loaded into the output
// register when that register is empty or being read, and is offered from there.
// One word per cycle unless the output stalls; each stage holds while its downstream stalls.
// The line pointers, fill count and current line length update as a word moves to the output.
// Reset (rst_n low at a clock edge) empties both stages, opens slot 0 as the
// only line with length zero, and sets the line width to 80.
`default_nettype none

module console_line_ring_writer_top
  import clrw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [7:0]            cfg_data,    // line_width

  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,    // char_in

  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // line_index[5:0], column[12:6], char_out[20:13], oldest_line[26:21],
  // lines_held[33:27], zero fill[39:34]
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // stored[0], newline_taken[1]
  output logic [OUT_USER_W-1:0]      out_tuser
);

  logic [7:0]              width_r;
  logic                    in_v_r;
  logic [7:0]              in_ch_r;
  logic                    out_v_r;
  logic [OUT_DATA_W-1:0]   out_data_r;
  logic [OUT_USER_W-1:0]   out_user_r;

  slot_t                   newest_r, newest_nxt;
  slot_t                   oldest_r, oldest_nxt;
  cnt_t                    count_r, count_nxt;
  len_t                    len_r, len_nxt;

  logic [7:0]              line_mem [MAX_LINES*MAX_WIDTH];

  logic                    out_adv;
  logic                    fire;
  logic                    is_lf;
  logic                    is_cr;
  logic                    is_char;
  logic                    wrap;
  logic                    open_ln;
  logic                    full;
  len_t                    eff_w;
  len_t                    col_base;
  logic                    do_write;
  logic [ADDR_W-1:0]       wr_addr;
  logic [OUT_DATA_W-1:0]   data_nxt;
  logic [OUT_USER_W-1:0]   user_nxt;

  function automatic slot_t next_slot(input slot_t s);
    if (s == slot_t'(MAX_LINES - 1)) begin
      return '0;
    end else begin
      return s + slot_t'(1);
    end
  endfunction

  assign cfg_ready  = 1'b1;
  assign out_adv    = !out_v_r || out_tready;
  assign in_tready  = !in_v_r || out_adv;
  assign fire       = in_v_r && out_adv;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_comb begin
    if (width_r == 8'd0) begin
      eff_w = len_t'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      eff_w = len_t'(MAX_WIDTH);
    end else begin
      eff_w = len_t'(width_r);
    end
  end

  always_comb begin
    is_lf   = (in_ch_r == CH_LF);
    is_cr   = (in_ch_r == CH_CR);
    is_char = !is_lf && !is_cr;
    wrap    = is_char && (len_r >= eff_w);
    open_ln = is_lf || wrap;
    full    = (count_r >= cnt_t'(MAX_LINES));

    newest_nxt = open_ln ? next_slot(newest_r) : newest_r;
    oldest_nxt = (open_ln && full) ? next_slot(oldest_r) : oldest_r;
    count_nxt  = (open_ln && !full) ? count_r + cnt_t'(1) : count_r;

    col_base = open_ln ? '0 : len_r;
    do_write = is_char && (32'(col_base) < MAX_WIDTH);
    len_nxt  = do_write ? col_base + len_t'(1) : col_base;
    wr_addr  = ADDR_W'(32'(newest_nxt) * MAX_WIDTH + 32'(col_base));

    data_nxt = '0;
    data_nxt[5:0]   = 6'(newest_nxt);
    data_nxt[12:6]  = is_char ? 7'(col_base) : 7'd0;
    data_nxt[20:13] = is_char ? in_ch_r : 8'd0;
    data_nxt[26:21] = 6'(oldest_nxt);
    data_nxt[33:27] = 7'(count_nxt);
    user_nxt = {open_ln, is_char};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      in_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      newest_r <= '0;
      oldest_r <= '0;
      count_r  <= cnt_t'(1);
      len_r    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        width_r <= cfg_data;
      end
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (out_adv) begin
        out_v_r <= in_v_r;
      end
      if (fire) begin
        newest_r <= newest_nxt;
        oldest_r <= oldest_nxt;
        count_r  <= count_nxt;
        len_r    <= len_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_ch_r <= in_tdata;
    end
    if (fire) begin
      out_data_r <= data_nxt;
      out_user_r <= user_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && do_write) begin
      line_mem[wr_addr] <= in_ch_r;
    end
  end

endmodule

`default_nettype wire

[tb/sv/console_line_ring_writer_top_test.sv]
module console_line_ring_writer_top_test;
  import clrw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       stored;
    logic       newline_taken;
    slot_t      line_index;
    logic [6:0] column;
    logic [7:0] char_out;
    slot_t      oldest_line;
    cnt_t       lines_held;
  } line_event_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [7:0]            cfg_data = 8'd0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = 8'd0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  console_line_ring_writer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  logic [7:0]  text_bytes[$];
  line_event_t pending_events[$];

  int unsigned line_len[MAX_LINES];
  int unsigned newest_line = 0;
  int unsigned oldest_held = 0;
  int unsigned lines_in_ring = 1;
  int unsigned wrap_width = 80;

  bit          idle_on = 1'b0;
  int          send_gap = 0;
  int          recv_hold = 0;
  int          long_holds_wanted = 0;
  int          long_holds_done = 0;
  int          bad_words = 0;
  int          draw;
  line_event_t seen;
  line_event_t want;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("Some tests failed");
    $finish;
  end

  function automatic void queue_byte(logic [7:0] b);
    text_bytes = {text_bytes, b};
  endfunction

  function automatic void open_line();
    newest_line = (newest_line + 1 >= MAX_LINES) ? 0 : newest_line + 1;
    line_len[newest_line] = 0;
    if (lines_in_ring >= MAX_LINES) begin
      oldest_held = (oldest_held + 1 >= MAX_LINES) ? 0 : oldest_held + 1;
    end else begin
      lines_in_ring++;
    end
  endfunction

  function automatic line_event_t advance_ring(logic [7:0] ch);
    line_event_t ev;
    int unsigned eff;
    int unsigned col;
    ev = '0;
    if (ch == CH_LF) begin
      open_line();
      ev.newline_taken = 1'b1;
    end else if (ch != CH_CR) begin
      eff = (wrap_width == 0) ? 1 : (wrap_width > MAX_WIDTH) ? MAX_WIDTH : wrap_width;
      if (line_len[newest_line] >= eff) begin
        open_line();
        ev.newline_taken = 1'b1;
      end
      col = line_len[newest_line];
      if (col < MAX_WIDTH) line_len[newest_line] = col + 1;
      ev.stored = 1'b1;
      ev.column = col[6:0];
      ev.char_out = ch;
    end
    ev.line_index = newest_line[SLOT_W-1:0];
    ev.oldest_line = oldest_held[SLOT_W-1:0];
    ev.lines_held = lines_in_ring[CNT_W-1:0];
    return ev;
  endfunction

  // Sender: one word per queued byte, with a drawn gap after each one while idle_on is set.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) pending_events = {pending_events, advance_ring(in_tdata)};
      if (in_tvalid && !in_tready) begin
        in_tvalid <= 1'b1;
      end else if (send_gap > 0) begin
        in_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (text_bytes.size() > 0) begin
        in_tdata <= text_bytes.pop_front();
        in_tvalid <= 1'b1;
        send_gap <= idle_on ? $urandom_range(0, 15) : 0;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: checks every accepted word against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_hold <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen.stored        = out_tuser[0];
        seen.newline_taken = out_tuser[1];
        seen.line_index    = out_tdata[5:0];
        seen.column        = out_tdata[12:6];
        seen.char_out      = out_tdata[20:13];
        seen.oldest_line   = out_tdata[26:21];
        seen.lines_held    = out_tdata[33:27];
        if (pending_events.size() == 0) begin
          bad_words++;
          if (bad_words <= 10) $display("Unexpected result word: %p", seen);
        end else begin
          want = pending_events.pop_front();
          if (seen !== want) begin
            bad_words++;
            if (bad_words <= 10) begin
              $display("Mismatch: expected %p", want);
              $display("          actual   %p", seen);
            end
          end
        end
      end
      if (long_holds_done < long_holds_wanted) begin
        out_tready <= 1'b0;
        recv_hold <= 300;
        long_holds_done <= long_holds_done + 1;
      end else if (recv_hold > 0) begin
        out_tready <= 1'b0;
        recv_hold <= recv_hold - 1;
      end else if (out_tvalid && out_tready) begin
        draw = idle_on ? $urandom_range(0, 15) : 0;
        recv_hold <= draw;
        out_tready <= (draw == 0);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic wait_drained();
    while (text_bytes.size() > 0 || in_tvalid || pending_events.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_width(logic [7:0] w);
    cfg_data <= w;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    wrap_width = w;
    cfg_valid <= 1'b0;
  endtask

  // Mostly printable text with breaks and CR-LF pairs, some raw bytes.
  task automatic queue_text(int count);
    int k;
    int pick;
    k = 0;
    while (k < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 58) queue_byte(8'($urandom_range(32, 126)));
      else if (pick < 68) queue_byte(8'd32);
      else if (pick < 76) queue_byte(CH_LF);
      else if (pick < 82) begin
        queue_byte(CH_CR);
        queue_byte(CH_LF);
        k++;
      end else if (pick < 86) queue_byte(CH_CR);
      else queue_byte(8'($urandom_range(0, 255)));
      k++;
    end
  endtask

  initial begin
    logic [7:0] widths[8];
    foreach (line_len[i]) line_len[i] = 0;
    widths = '{8'd1, 8'd128, 8'd0, 8'd255, 8'd2, 8'd0, 8'd80, 8'd129};
    widths[5] = 8'($urandom_range(1, 128));
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_on = 1'b1;
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h41);
    queue_byte(CH_CR);
    queue_byte(CH_LF);
    queue_byte(8'h55);
    queue_byte(8'hAA);
    queue_byte(CH_CR);
    queue_byte(8'h80);
    queue_byte(8'h7F);
    queue_byte(CH_LF);
    queue_byte(CH_LF);
    queue_byte(8'h01);
    queue_byte(8'hFE);
    queue_byte(CH_CR);
    queue_byte(CH_CR);
    queue_byte(8'h0B);
    queue_byte(8'h0C);
    wait_drained();

    write_width(8'd1);
    queue_byte(8'h61);
    queue_byte(8'h62);
    queue_byte(CH_CR);
    queue_byte(CH_LF);
    queue_byte(8'h63);
    wait_drained();

    foreach (widths[i]) begin
      write_width(widths[i]);
      idle_on = (i % 2 == 0);
      if (i == 2) long_holds_wanted = long_holds_wanted + 1;
      queue_text(150);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (bad_words == 0 && pending_events.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
src/clrw_pkg.sv
src/console_line_ring_writer_top.sv
tb/sv/console_line_ring_writer_top_test.sv
